>>> rtl/nv21rgb_pkg.sv
package nv21rgb_pkg;

    localparam int DIM_W  = 12;
    localparam int THR_W  = 9;
    localparam int DEST_W = 22;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam logic [DIM_W-1:0] WIDTH_RESET     = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET    = 12'd480;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 9'd30;
    localparam int               MIN_WIDTH       = 2;
    localparam int               MIN_HEIGHT      = 1;
    localparam logic [7:0]       CHROMA_BIAS     = 8'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD = 2'd2;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [DEST_W-1:0] dest_index;
        logic              frame_last;
        logic              dark_frame;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
    } t_ycc;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                    input int lo, input int hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (int'(v) < lo) begin
            res = DIM_W'(lo);
        end else if (int'(v) > hi) begin
            res = DIM_W'(hi);
        end
        return res;
    endfunction

endpackage

>>> rtl/nv21rgb_csc.sv
module nv21rgb_csc
    import nv21rgb_pkg::*;
(
    input  t_ycc i_ycc,
    output t_rgb o_rgb
);

    function automatic logic [7:0] clamp8(input logic signed [11:0] v);
        logic [7:0] res;
        res = v[7:0];
        if (v < 12'sd0) begin
            res = 8'd0;
        end else if (v > 12'sd255) begin
            res = 8'd255;
        end
        return res;
    endfunction

    logic signed [11:0] y;
    logic signed [11:0] cb;
    logic signed [11:0] cr;
    logic signed [11:0] sum_r;
    logic signed [11:0] sum_g;
    logic signed [11:0] sum_b;

    assign y  = $signed({4'b0, i_ycc.luma});
    assign cb = $signed({4'b0, i_ycc.cb}) - $signed({4'b0, CHROMA_BIAS});
    assign cr = $signed({4'b0, i_ycc.cr}) - $signed({4'b0, CHROMA_BIAS});

    // shift-add approximation, floor shifts
    assign sum_r = y + cr + (cr >>> 2) + (cr >>> 3) + (cr >>> 5);
    assign sum_g = y - (cb >>> 2) + (cb >>> 4) + (cb >>> 5)
                 - (cr >>> 1) + (cr >>> 3) + (cr >>> 4) + (cr >>> 5);
    assign sum_b = y + cb + (cb >>> 1) + (cb >>> 2) + (cb >>> 6);

    assign o_rgb.red   = clamp8(sum_r);
    assign o_rgb.green = clamp8(sum_g);
    assign o_rgb.blue  = clamp8(sum_b);

endmodule

>>> rtl/nv21_to_rgb_rotate_dark_detect_unit.sv
// channel   direction  handshake                  word
// in        input      i_in_valid / o_in_ready    i_in_data  (t_pix_in)
// out       output     o_out_valid / i_out_ready  o_out_data (t_pix_out)
// cfg       input      i_cfg_wr_en, no wait       i_cfg_index, i_cfg_data
//
// three register stages: input/counters, color conversion, dark count
// one word per clock sustained while i_out_ready is high; a word passes each stage register in turn
// each stage moves on when the one after it is empty or moving
// i_rst_n synchronous active low: counters, chroma, size and threshold to defaults
// a size write restarts the frame and clears the dark count
module nv21_to_rgb_rotate_dark_detect_unit
    import nv21rgb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pix_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_pix_out              o_out_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CNT_W = $clog2(5 * MAX_WIDTH * MAX_HEIGHT + 1);
    localparam logic [DIM_W-1:0] W_RST = clamp_dim(WIDTH_RESET, MIN_WIDTH, MAX_WIDTH);
    localparam logic [DIM_W-1:0] H_RST = clamp_dim(HEIGHT_RESET, MIN_HEIGHT, MAX_HEIGHT);
    localparam logic [CNT_W-1:0] AREA4_RST = CNT_W'(4 * int'(W_RST) * int'(H_RST));

    // configuration
    logic [DIM_W-1:0] r_w_eff;
    logic [DIM_W-1:0] r_h_eff;
    logic [THR_W-1:0] r_thr;
    logic [CNT_W-1:0] r_area4;
    logic             size_wr;
    logic [2*DIM_W-1:0] area;

    // frame position
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [7:0]        r_held_cb;
    logic [7:0]        r_held_cr;
    logic [DEST_W-1:0] r_dest;

    // pipeline
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    t_ycc              r_ycc1;
    logic [DEST_W-1:0] r_dest1;
    logic              r_last1;
    t_rgb              r_rgb2;
    logic [DEST_W-1:0] r_dest2;
    logic              r_last2;
    t_pix_out          r_out;
    logic [CNT_W-1:0]  r_count5;

    logic              adv1;
    logic              adv2;
    logic              adv3;
    logic              take;
    logic              col_last;
    logic              row_last;
    logic [7:0]        n_cb;
    logic [7:0]        n_cr;
    logic [DEST_W-1:0] n_dest;
    logic [DEST_W-1:0] row_base;
    t_rgb              rgb1;
    logic              pix_dark;
    logic [CNT_W-1:0]  n_count5;
    logic              verdict;

    assign adv3 = !r_v3 || i_out_ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_in_ready = adv1;
    assign take = i_in_valid && adv1;

    assign size_wr = i_cfg_wr_en &&
                     (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT);
    assign area = (2*DIM_W)'(r_w_eff) * (2*DIM_W)'(r_h_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff <= W_RST;
            r_h_eff <= H_RST;
            r_thr   <= THRESHOLD_RESET;
            r_area4 <= AREA4_RST;
        end else begin
            r_area4 <= CNT_W'({area, 2'b00});
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        r_w_eff <= clamp_dim(i_cfg_data[DIM_W-1:0], MIN_WIDTH, MAX_WIDTH);
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_h_eff <= clamp_dim(i_cfg_data[DIM_W-1:0], MIN_HEIGHT, MAX_HEIGHT);
                    end
                    CFG_DARK_THRESHOLD: begin
                        r_thr <= i_cfg_data[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // stage 0: position, chroma reuse, rotated index
    assign col_last = (14'(r_col) == 14'(r_w_eff) - 14'd1);
    assign row_last = (14'(r_row) == 14'(r_h_eff) - 14'd1);
    assign n_cb = r_col[0] ? r_held_cb : i_in_data.chroma_blue;
    assign n_cr = r_col[0] ? r_held_cr : i_in_data.chroma_red;
    assign row_base = DEST_W'(r_h_eff) - DEST_W'(1) - DEST_W'(r_row);
    assign n_dest = (r_col == '0) ? row_base : r_dest + DEST_W'(r_h_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_held_cb <= '0;
            r_held_cr <= '0;
        end else if (size_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (take) begin
            r_held_cb <= n_cb;
            r_held_cr <= n_cr;
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_dest       <= n_dest;
            r_dest1      <= n_dest;
            r_last1      <= col_last && row_last;
            r_ycc1.luma  <= i_in_data.luma;
            r_ycc1.cb    <= n_cb;
            r_ycc1.cr    <= n_cr;
        end
    end

    // stage 1: color conversion
    nv21rgb_csc u_csc (
        .i_ycc (r_ycc1),
        .o_rgb (rgb1)
    );

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_rgb2  <= rgb1;
            r_dest2 <= r_dest1;
            r_last2 <= r_last1;
        end
    end

    // stage 2: dark count and frame verdict
    assign pix_dark = ({1'b0, r_rgb2.red} < r_thr) && ({1'b0, r_rgb2.green} < r_thr) &&
                      ({1'b0, r_rgb2.blue} < r_thr);
    assign n_count5 = r_count5 + (pix_dark ? CNT_W'(5) : CNT_W'(0));
    assign verdict  = r_last2 && (n_count5 >= r_area4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count5 <= '0;
        end else if (size_wr) begin
            r_count5 <= '0;
        end else if (adv3 && r_v2) begin
            r_count5 <= r_last2 ? '0 : n_count5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_out.red        <= r_rgb2.red;
            r_out.green      <= r_rgb2.green;
            r_out.blue       <= r_rgb2.blue;
            r_out.dest_index <= r_dest2;
            r_out.frame_last <= r_last2;
            r_out.dark_frame <= verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= take;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_dark_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.frame_last || !o_out_data.dark_frame))
        else $error("dark_frame without frame_last");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        14'(r_col) < 14'(r_w_eff) && 14'(r_row) < 14'(r_h_eff))
        else $error("frame position beyond frame size");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv3 && r_v2 && r_last2) |=> (r_count5 == '0))
        else $error("dark count not cleared at frame end");

    a_first_col_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_col == '0 && !size_wr) |=> (r_dest1 == row_base))
        else $error("row start index wrong");
`endif

endmodule
